// ===== rtl/core/qlfifo_pkg.sv =====
// Shared types and constants for the quantity-limited FIFO.
// Used by the cell, the top level and the bench; no dependencies.
package qlfifo_pkg;
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 16;
  localparam int QTY_W       = 32;
  localparam int ID_W        = 16;
  localparam int CNT_W       = 5;
  localparam int ST_W        = 3;

  localparam logic [1:0] FN_PUSH    = 2'd0;
  localparam logic [1:0] FN_POP_ONE = 2'd1;
  localparam logic [1:0] FN_POP_CNT = 2'd2;
  localparam logic [1:0] FN_POP_QTY = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_OVER_CAP = 3'd1;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
  localparam logic [ST_W-1:0] ST_FEW_ENT  = 3'd3;
  localparam logic [ST_W-1:0] ST_FEW_QTY  = 3'd4;
  localparam logic [ST_W-1:0] ST_ZERO_QTY = 3'd5;

  // per-cycle command broadcast from the controller to every cell
  typedef struct packed {
    logic shift;   // every cell takes its upstream neighbour's entry
    logic load;    // cell whose slot equals the fill level captures the push
    logic trim;    // head cell subtracts trim_qty from its quantity
  } cell_ctl_t;
endpackage

// ===== rtl/core/qlfifo_cell.sv =====
// One storage cell of the shifting entry chain.
// Depends on qlfifo_pkg. Cell 0 is the head; data moves towards it on a shift.
module qlfifo_cell #(
  parameter int ID_BITS = qlfifo_pkg::ID_BITS_DEF,
  parameter int CW      = 5
) (
  input  logic                        clk,
  input  qlfifo_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]               slot,
  input  logic [CW-1:0]               fill,
  input  logic [ID_BITS-1:0]          push_id,
  input  logic [qlfifo_pkg::QTY_W-1:0] push_qty,
  input  logic [qlfifo_pkg::QTY_W-1:0] trim_qty,
  input  logic [ID_BITS-1:0]          up_id,
  input  logic [qlfifo_pkg::QTY_W-1:0] up_qty,
  output logic [ID_BITS-1:0]          id_r,
  output logic [qlfifo_pkg::QTY_W-1:0] qty_r,
  output logic                        hit
);
  logic [ID_BITS-1:0]           id_nxt;
  logic [qlfifo_pkg::QTY_W-1:0] qty_nxt;

  assign hit = (slot < fill) && (id_r == push_id);

  always_comb begin
    id_nxt  = id_r;
    qty_nxt = qty_r;
    if (ctl.shift) begin
      id_nxt  = up_id;
      qty_nxt = up_qty;
    end else if (ctl.load && slot == fill) begin
      id_nxt  = push_id;
      qty_nxt = push_qty;
    end else if (ctl.trim && slot == '0) begin
      qty_nxt = qty_r - trim_qty;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    qty_r <= qty_nxt;
  end
endmodule

// ===== rtl/core/quantity_limited_fifo_with_split_core.sv =====
// Quantity-limited FIFO, top level: controller, output register and cell chain.
// Push and error items give their one result from the decode state through the output
// register; a pop that removes entries first scans the chain entry by entry so that
// every piece carries the post-item totals, then emits one piece per cycle while the
// output does not stall.
// One item at a time: in_stall stays high until its last result is in the output register.
// Reset (rst_n, synchronous): empty, capacity 0; entry storage is not cleared.
module quantity_limited_fifo_with_split_core #(
  parameter int DEPTH   = qlfifo_pkg::DEPTH_DEF,
  parameter int ID_BITS = qlfifo_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [qlfifo_pkg::QTY_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [qlfifo_pkg::ID_W-1:0]       in_item_id,
  input  logic [qlfifo_pkg::QTY_W-1:0]      in_item_qty,
  input  logic [qlfifo_pkg::CNT_W-1:0]      in_pop_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [qlfifo_pkg::ST_W-1:0]       out_status,
  output logic [qlfifo_pkg::ID_W-1:0]       out_out_id,
  output logic [qlfifo_pkg::QTY_W-1:0]      out_out_qty,
  output logic                              out_last,
  output logic [qlfifo_pkg::QTY_W-1:0]      out_total_qty,
  output logic [qlfifo_pkg::CNT_W-1:0]      out_entry_count
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = qlfifo_pkg::QTY_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [QW-1:0]         cap_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [QW-1:0]         tot_r, tot_nxt;
  logic [1:0]            func_r;
  logic [ID_BITS-1:0]    id_r;
  logic [QW-1:0]         left_r, left_nxt;
  logic [CW:0]           want_r, want_nxt;
  logic                  ov_r, ov_nxt;
  logic [qlfifo_pkg::ST_W-1:0] o_st_r, o_st_nxt;
  logic [ID_BITS-1:0]    o_id_r, o_id_nxt;
  logic [QW-1:0]         o_q_r, o_q_nxt;
  logic                  o_last_r, o_last_nxt;
  logic [QW-1:0]         o_tot_r, o_tot_nxt;
  logic [CW-1:0]         o_cnt_r, o_cnt_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [QW-1:0]         acc_r, acc_nxt;
  logic [QW-1:0]         fin_tot_r, fin_tot_nxt;
  logic [CW-1:0]         fin_cnt_r, fin_cnt_nxt;
  logic [QW:0]           scan_sum;

  qlfifo_pkg::cell_ctl_t ctl;
  logic [ID_BITS-1:0]    c_id  [DEPTH+1];
  logic [QW-1:0]         c_qty [DEPTH+1];
  logic [DEPTH-1:0]      hits;
  logic [QW-1:0]         trim_q;

  assign c_id[DEPTH]  = '0;
  assign c_qty[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    qlfifo_cell #(.ID_BITS(ID_BITS), .CW(CW)) u_cell (
      .clk(clk), .ctl(ctl), .slot(CW'(g)), .fill(cnt_r),
      .push_id(id_r), .push_qty(left_r), .trim_qty(trim_q),
      .up_id(c_id[g+1]), .up_qty(c_qty[g+1]),
      .id_r(c_id[g]), .qty_r(c_qty[g]), .hit(hits[g])
    );
  end

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign trim_q   = left_r;
  // running sum of the entries from the head up to the scan position
  assign scan_sum = {1'b0, acc_r} + {1'b0, c_qty[k_r]};

  always_comb begin
    logic [QW:0] sum;
    logic [QW-1:0] hq;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    tot_nxt     = tot_r;
    left_nxt    = left_r;
    want_nxt    = want_r;
    ov_nxt      = ov_r && out_stall;
    o_st_nxt    = o_st_r;
    o_id_nxt    = o_id_r;
    o_q_nxt     = o_q_r;
    o_last_nxt  = o_last_r;
    o_tot_nxt   = o_tot_r;
    o_cnt_nxt   = o_cnt_r;
    k_nxt       = k_r;
    acc_nxt     = acc_r;
    fin_tot_nxt = fin_tot_r;
    fin_cnt_nxt = fin_cnt_r;
    ctl         = '0;
    sum         = {1'b0, tot_r} + {1'b0, left_r};
    hq          = c_qty[0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
          left_nxt  = in_item_qty;
          want_nxt  = (in_func == qlfifo_pkg::FN_POP_ONE) ? (CW+1)'(1)
                                                          : (CW+1)'(in_pop_count);
        end
      end
      S_DEC: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_st_nxt   = qlfifo_pkg::ST_OK;
          o_id_nxt   = '0;
          o_q_nxt    = '0;
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
          case (func_r)
            qlfifo_pkg::FN_PUSH: begin
              if (sum > {1'b0, cap_r})     o_st_nxt = qlfifo_pkg::ST_OVER_CAP;
              else if (|hits)              o_st_nxt = qlfifo_pkg::ST_DUP;
              else if (cnt_r >= DEPTH_C)   o_st_nxt = qlfifo_pkg::ST_OVER_CAP;
              else begin
                ctl.load = 1'b1;
                cnt_nxt  = cnt_r + 1'b1;
                tot_nxt  = sum[QW-1:0];
              end
            end
            qlfifo_pkg::FN_POP_ONE, qlfifo_pkg::FN_POP_CNT: begin
              if (want_r > {1'b0, cnt_r}) o_st_nxt = qlfifo_pkg::ST_FEW_ENT;
              else if (want_r != '0) begin
                ov_nxt    = 1'b0;
                k_nxt     = '0;
                acc_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (left_r > tot_r)        o_st_nxt = qlfifo_pkg::ST_FEW_QTY;
              else if (left_r == '0)     o_st_nxt = qlfifo_pkg::ST_ZERO_QTY;
              else begin
                ov_nxt    = 1'b0;
                k_nxt     = '0;
                acc_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
          o_tot_nxt = tot_nxt;
          o_cnt_nxt = cnt_nxt;
        end
      end
      // find the totals left after the whole pop before the first piece goes out
      S_SCAN: begin
        if (func_r == qlfifo_pkg::FN_POP_QTY) begin
          if (k_r == cnt_r || acc_r == left_r || scan_sum > {1'b0, left_r}) begin
            fin_tot_nxt = tot_r - left_r;
            fin_cnt_nxt = cnt_r - k_r;
            state_nxt   = S_POP;
          end else begin
            acc_nxt = scan_sum[QW-1:0];
            k_nxt   = k_r + 1'b1;
          end
        end else begin
          if ({1'b0, k_r} == want_r) begin
            fin_tot_nxt = tot_r - acc_r;
            fin_cnt_nxt = cnt_r - k_r;
            state_nxt   = S_POP;
          end else begin
            acc_nxt = scan_sum[QW-1:0];
            k_nxt   = k_r + 1'b1;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_st_nxt  = qlfifo_pkg::ST_OK;
          o_id_nxt  = c_id[0];
          o_tot_nxt = fin_tot_r;
          o_cnt_nxt = fin_cnt_r;
          if (func_r == qlfifo_pkg::FN_POP_QTY) begin
            if (hq > left_r) begin
              ctl.trim   = 1'b1;
              o_q_nxt    = left_r;
              tot_nxt    = tot_r - left_r;
              left_nxt   = '0;
            end else begin
              ctl.shift  = 1'b1;
              o_q_nxt    = hq;
              tot_nxt    = tot_r - hq;
              cnt_nxt    = cnt_r - 1'b1;
              left_nxt   = left_r - hq;
            end
            o_last_nxt = (left_nxt == '0) || (cnt_nxt == '0);
          end else begin
            ctl.shift  = 1'b1;
            o_q_nxt    = hq;
            tot_nxt    = tot_r - hq;
            cnt_nxt    = cnt_r - 1'b1;
            want_nxt   = want_r - 1'b1;
            o_last_nxt = (want_nxt == '0);
          end
          if (o_last_nxt) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= '0;
      cnt_r   <= '0;
      tot_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_func;
      id_r   <= in_item_id[ID_BITS-1:0];
    end
    left_r    <= left_nxt;
    want_r    <= want_nxt;
    o_st_r    <= o_st_nxt;
    o_id_r    <= o_id_nxt;
    o_q_r     <= o_q_nxt;
    o_last_r  <= o_last_nxt;
    o_tot_r   <= o_tot_nxt;
    o_cnt_r   <= o_cnt_nxt;
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    fin_tot_r <= fin_tot_nxt;
    fin_cnt_r <= fin_cnt_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = o_st_r;
  assign out_out_id      = qlfifo_pkg::ID_W'(o_id_r);
  assign out_out_qty     = o_q_r;
  assign out_last        = o_last_r;
  assign out_total_qty   = o_tot_r;
  assign out_entry_count = qlfifo_pkg::CNT_W'(o_cnt_r);
endmodule

// ===== bench/qlfifo_scoreboard.sv =====
// Checker for the quantity-limited FIFO: watches the item channels and the capacity port.
// Keeps its own copy of the FIFO, predicts every result and compares; needs qlfifo_pkg.
module qlfifo_scoreboard (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qlfifo_pkg::QTY_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic [qlfifo_pkg::ID_W-1:0]      in_item_id,
  input  logic [qlfifo_pkg::QTY_W-1:0]     in_item_qty,
  input  logic [qlfifo_pkg::CNT_W-1:0]     in_pop_count,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [qlfifo_pkg::ST_W-1:0]      out_status,
  input  logic [qlfifo_pkg::ID_W-1:0]      out_out_id,
  input  logic [qlfifo_pkg::QTY_W-1:0]     out_out_qty,
  input  logic                             out_last,
  input  logic [qlfifo_pkg::QTY_W-1:0]     out_total_qty,
  input  logic [qlfifo_pkg::CNT_W-1:0]     out_entry_count,
  output int                               fail_count,
  output int                               pending,
  output logic [qlfifo_pkg::QTY_W-1:0]     held_total
);
  localparam int NSLOT = qlfifo_pkg::DEPTH_DEF;
  localparam int NEXP  = 64;
  localparam int QW    = qlfifo_pkg::QTY_W;
  localparam int IW    = qlfifo_pkg::ID_W;

  typedef struct packed {
    logic [qlfifo_pkg::ST_W-1:0]  status;
    logic [IW-1:0]                id;
    logic [QW-1:0]                qty;
    logic                         last;
    logic [QW-1:0]                total;
    logic [qlfifo_pkg::CNT_W-1:0] count;
  } piece_t;

  // expected results, kept in a ring
  piece_t           exp_buf[NEXP];
  piece_t           step_buf[NSLOT];
  int               exp_rd, exp_wr, exp_n, n_step;
  logic [IW-1:0]    slot_id [NSLOT];
  logic [QW-1:0]    slot_qty[NSLOT];
  int               head, tail, count;
  logic [QW-1:0]    total, cap;

  function automatic int next_slot(int p);
    return (p + 1 >= NSLOT) ? 0 : p + 1;
  endfunction

  function automatic piece_t mk(logic [qlfifo_pkg::ST_W-1:0] s, logic [IW-1:0] i,
                                logic [QW-1:0] q);
    piece_t r;
    r = '0;
    r.status = s;
    r.id = i;
    r.qty = q;
    return r;
  endfunction

  task automatic add_step(piece_t p);
    step_buf[n_step] = p;
    n_step++;
  endtask

  task automatic take_head();
    total = total - slot_qty[head];
    head = next_slot(head);
    count--;
  endtask

  task automatic predict_item(logic [1:0] fn, logic [IW-1:0] id, logic [QW-1:0] q,
                              logic [qlfifo_pkg::CNT_W-1:0] num);
    bit               dup;
    int               p, want;
    logic [QW-1:0]    left;
    n_step = 0;
    if (fn == qlfifo_pkg::FN_PUSH) begin
      dup = 0;
      p = head;
      for (int i = 0; i < count; i++) begin
        if (slot_id[p] == id) dup = 1;
        p = next_slot(p);
      end
      if ({1'b0, total} + {1'b0, q} > {1'b0, cap}) add_step(mk(qlfifo_pkg::ST_OVER_CAP, 0, 0));
      else if (dup) add_step(mk(qlfifo_pkg::ST_DUP, 0, 0));
      else if (count >= NSLOT) add_step(mk(qlfifo_pkg::ST_OVER_CAP, 0, 0));
      else begin
        slot_id[tail] = id;
        slot_qty[tail] = q;
        tail = next_slot(tail);
        count++;
        total = total + q;
        add_step(mk(qlfifo_pkg::ST_OK, 0, 0));
      end
    end else if (fn == qlfifo_pkg::FN_POP_ONE || fn == qlfifo_pkg::FN_POP_CNT) begin
      want = (fn == qlfifo_pkg::FN_POP_ONE) ? 1 : int'(num);
      if (want > count) add_step(mk(qlfifo_pkg::ST_FEW_ENT, 0, 0));
      else if (want == 0) add_step(mk(qlfifo_pkg::ST_OK, 0, 0));
      else
        for (int i = 0; i < want; i++) begin
          add_step(mk(qlfifo_pkg::ST_OK, slot_id[head], slot_qty[head]));
          take_head();
        end
    end else begin
      if (q > total) add_step(mk(qlfifo_pkg::ST_FEW_QTY, 0, 0));
      else if (q == 0) add_step(mk(qlfifo_pkg::ST_ZERO_QTY, 0, 0));
      else begin
        left = q;
        while (left > 0 && count > 0 && n_step < NSLOT) begin
          if (slot_qty[head] > left) begin
            // head larger than what is wanted: split, remainder stays at head
            add_step(mk(qlfifo_pkg::ST_OK, slot_id[head], left));
            slot_qty[head] = slot_qty[head] - left;
            total = total - left;
            left = 0;
          end else begin
            add_step(mk(qlfifo_pkg::ST_OK, slot_id[head], slot_qty[head]));
            left = left - slot_qty[head];
            take_head();
          end
        end
      end
    end
    for (int k = 0; k < n_step; k++) begin
      step_buf[k].total = total;
      step_buf[k].count = qlfifo_pkg::CNT_W'(count);
      step_buf[k].last = (k == n_step - 1);
      exp_buf[exp_wr] = step_buf[k];
      exp_wr = (exp_wr + 1) % NEXP;
      exp_n++;
    end
  endtask

  task automatic compare_piece();
    piece_t e;
    if (exp_n == 0) begin
      $error("result item with nothing expected");
      fail_count++;
    end else begin
      e = exp_buf[exp_rd];
      exp_rd = (exp_rd + 1) % NEXP;
      exp_n--;
      if (out_status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, out_status); fail_count++;
      end
      if (out_out_id !== e.id) begin
        $error("out_id: expected %h actual %h", e.id, out_out_id); fail_count++;
      end
      if (out_out_qty !== e.qty) begin
        $error("out_qty: expected %h actual %h", e.qty, out_out_qty); fail_count++;
      end
      if (out_last !== e.last) begin
        $error("last: expected %0d actual %0d", e.last, out_last); fail_count++;
      end
      if (out_total_qty !== e.total) begin
        $error("total_qty: expected %h actual %h", e.total, out_total_qty); fail_count++;
      end
      if (out_entry_count !== e.count) begin
        $error("entry_count: expected %0d actual %0d", e.count, out_entry_count);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    head = 0; tail = 0; count = 0; total = '0; cap = '0;
    exp_rd = 0; exp_wr = 0; exp_n = 0; n_step = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      head = 0; tail = 0; count = 0; total = '0; cap = '0;
      exp_rd = 0; exp_wr = 0; exp_n = 0;
    end else begin
      if (out_valid && !out_stall) compare_piece();
      if (cfg_we) cap = cfg_wdata;
      if (in_valid && !in_stall) predict_item(in_func, in_item_id, in_item_qty, in_pop_count);
    end
    pending <= exp_n;
    held_total <= total;
  end

  // a result still owed at the end counts as a failure
  function automatic int leftover();
    return exp_n;
  endfunction
endmodule

// ===== bench/quantity_limited_fifo_with_split_core_tb.sv =====
// Testbench top for the quantity-limited FIFO: clock, reset, stimulus, verdict.
// Depends on qlfifo_pkg, the core and the qlfifo_scoreboard checker.
module quantity_limited_fifo_with_split_core_tb;
  localparam int IDLE_LIMIT = 3000;
  localparam int QW = qlfifo_pkg::QTY_W;
  localparam int IW = qlfifo_pkg::ID_W;
  localparam int NW = qlfifo_pkg::CNT_W;

  logic                        clk, rst_n;
  logic                        cfg_we;
  logic [QW-1:0]               cfg_wdata;
  logic                        in_valid, in_stall;
  logic [1:0]                  in_func;
  logic [IW-1:0]               in_item_id;
  logic [QW-1:0]               in_item_qty;
  logic [NW-1:0]               in_pop_count;
  logic                        out_valid, out_stall;
  logic [qlfifo_pkg::ST_W-1:0] out_status;
  logic [IW-1:0]               out_out_id;
  logic [QW-1:0]               out_out_qty;
  logic                        out_last;
  logic [QW-1:0]               out_total_qty;
  logic [NW-1:0]               out_entry_count;
  int                          fail_count, pending;
  logic [QW-1:0]               held_total;
  bit                          quiet, hold_out;
  int                          idle_cycles;
  logic [IW-1:0]               id_base;
  logic [QW-1:0]               cap_now;

  quantity_limited_fifo_with_split_core uut (.*);
  qlfifo_scoreboard chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0; in_func = qlfifo_pkg::FN_PUSH;
    in_item_id = '0; in_item_qty = '0; in_pop_count = '0; out_stall = 0;
    quiet = 0; hold_out = 0;
  end

  task automatic send(logic [1:0] fn, logic [IW-1:0] id, logic [QW-1:0] q,
                      logic [NW-1:0] num);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_func <= fn; in_item_id <= id; in_item_qty <= q; in_pop_count <= num;
    do @(posedge clk); while (in_stall);
  endtask

  // capacity changes only with nothing in flight
  task automatic set_capacity(logic [QW-1:0] v);
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    cap_now = v;
  endtask

  task automatic random_item();
    int            pick;
    logic [QW-1:0] q;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 3))
        0: q = $urandom;
        1: q = '0;
        default: q = $urandom_range(0, (cap_now >> 3));
      endcase
      send(qlfifo_pkg::FN_PUSH, id_base ^ IW'($urandom_range(0, 23)), q, NW'($urandom));
    end else if (pick < 60)
      send(qlfifo_pkg::FN_POP_ONE, IW'($urandom), $urandom, NW'($urandom));
    else if (pick < 75)
      send(qlfifo_pkg::FN_POP_CNT, IW'($urandom), $urandom,
           ($urandom_range(0, 4) == 0) ? NW'($urandom) : NW'($urandom_range(0, 4)));
    else begin
      if (held_total != 0 && $urandom_range(0, 4) != 0) q = $urandom_range(1, held_total);
      else q = $urandom;
      send(qlfifo_pkg::FN_POP_QTY, IW'($urandom), q, NW'($urandom));
    end
  endtask

  // receiver
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = quiet ? 0 : $urandom_range(0, 17);
      if (hold_out) k = 300;
      if (k > 0) begin
        out_stall <= 1;
        repeat (k) @(posedge clk);
        out_stall <= 0;
      end else out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cap_now = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // capacity 0: a zero push fits, anything else does not
    send(qlfifo_pkg::FN_PUSH, 16'h0000, 32'h0, 5'd0);
    send(qlfifo_pkg::FN_PUSH, 16'h0001, 32'h1, 5'd0);
    send(qlfifo_pkg::FN_POP_QTY, 16'h0, 32'h0, 5'd0);
    send(qlfifo_pkg::FN_POP_ONE, 16'h0, 32'h0, 5'd0);
    send(qlfifo_pkg::FN_POP_CNT, 16'h0, 32'h0, 5'd31);
    send(qlfifo_pkg::FN_POP_CNT, 16'h0, 32'h0, 5'd0);
    send(qlfifo_pkg::FN_POP_ONE, 16'h0, 32'h0, 5'd0);
    set_capacity(32'hFFFF_FFFF);
    send(qlfifo_pkg::FN_PUSH, 16'hFFFF, 32'hFFFF_FFFE, 5'd0);
    send(qlfifo_pkg::FN_PUSH, 16'h1234, 32'h2, 5'd0);     // 33-bit overflow
    send(qlfifo_pkg::FN_PUSH, 16'hFFFF, 32'h0, 5'd0);     // duplicate id
    send(qlfifo_pkg::FN_PUSH, 16'h0002, 32'h0, 5'd0);     // zero entry behind the big one
    send(qlfifo_pkg::FN_POP_QTY, 16'h0, 32'hFFFF_FFFF, 5'd0);
    send(qlfifo_pkg::FN_POP_QTY, 16'h0, 32'h0001_8000, 5'd0);
    send(qlfifo_pkg::FN_POP_QTY, 16'h0, 32'hFFFF_FFFD, 5'd0);
    send(qlfifo_pkg::FN_POP_ONE, 16'h0, 32'h0, 5'd0);
    // fill to depth behind the zero entry, two too many, then pop 17: more than held
    for (int i = 0; i < 17; i++)
      send(qlfifo_pkg::FN_PUSH, IW'(i * 16'h0F0F), 32'h0001_0000, 5'd0);
    send(qlfifo_pkg::FN_POP_CNT, 16'h0, 32'h0, 5'd17);
    send(qlfifo_pkg::FN_POP_QTY, 16'h0, 32'h0010_0000, 5'd0);
    // shrink capacity below the stored total
    for (int i = 0; i < 4; i++) send(qlfifo_pkg::FN_PUSH, IW'(i), 32'h0004_0000, 5'd0);
    set_capacity(32'h0002_0000);
    send(qlfifo_pkg::FN_PUSH, 16'h00AA, 32'h0, 5'd0);
    send(qlfifo_pkg::FN_POP_CNT, 16'h0, 32'h0, 5'd16);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_capacity(32'hFFFF_FFFF);
        1: set_capacity(32'h0000_0000);
        2: set_capacity(32'h0010_0000);
        default: set_capacity($urandom);
      endcase
      id_base = $urandom;
      quiet = (phase == 3);
      for (int i = 0; i < 15; i++) begin
        if (phase == 4 && i == 2) hold_out = 1;
        if (phase == 4 && i == 12) hold_out = 0;
        if (phase == 2 && i == 8) begin
          in_valid <= 0;
          @(posedge clk);
          wait (pending == 0);
        end
        random_item();
      end
    end
    hold_out = 0;
    quiet = 0;
    in_valid <= 0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && chk.leftover() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
